/* rtl/buddy_allocator_assert.svh */
// Assertion macros for the buddy allocator.
`ifndef BUDDY_ALLOCATOR_ASSERT_SVH
`define BUDDY_ALLOCATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BALLOC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buddy allocator check failed");

// antecedent implies consequent in the next cycle
`define BALLOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buddy allocator check failed");

`endif

/* rtl/balloc_pkg.sv */
// Shared types and codes of the buddy allocator.
`default_nettype none
package balloc_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;
   localparam int   TAG_W    = 5;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_SPACE = 2'd1,
      STAT_TOO_BIG  = 2'd2,
      STAT_BAD_FREE = 2'd3
   } status_type;

   typedef struct packed {
      logic        req_type;
      logic [15:0] request_size;
      logic [15:0] free_offset;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] user_offset;
      logic [3:0]  block_order;
   } rsp_item_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_TAG,
      S_DESC_RD,
      S_DESC,
      S_SPLIT,
      S_UP_RD,
      S_UP_WR
   } state_type;

   typedef struct packed {
      logic       clear_step;
      logic       load;
      logic       decode;
      logic       tag_apply;
      logic       descend;
      logic       split;
      logic       up_read;
      logic       up;
      logic       set_root;
      logic       finish;
      status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_free;
      logic too_big;
      logic no_space;
      logic bad_free;
      logic at_level;
      logic at_root;
   } dp_stat_type;

endpackage
`default_nettype wire

/* rtl/balloc_dp.sv */
// Buddy allocator datapath: summary tree memory, tag memory and walk registers.
`default_nettype none
module balloc_dp
   import balloc_pkg::*;
#(
   parameter int MIN_ORDER  = 5,
   parameter int POOL_ORDER = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   input  req_item_type req_data,
   output logic         rsp_valid,
   output rsp_item_type rsp_data
);
   localparam int LEVELS = POOL_ORDER - MIN_ORDER;
   localparam int W      = LEVELS + 1;
   localparam int NW     = LEVELS + 1;
   localparam int AW     = (LEVELS > 0) ? LEVELS : 1;
   localparam int DEPTH  = 1 << AW;
   localparam int RW     = 2 * W;

   logic [RW-1:0]    row_mem [DEPTH];
   logic [TAG_W-1:0] tag_mem [DEPTH];

   req_item_type     req_ff, req_in;
   logic [4:0]       k_ff, k_in, j_ff, j_in, lvl_ff, lvl_in;
   logic [NW-1:0]    node_ff, node_in;
   logic [W-1:0]     mask_ff, mask_in, root_ff, root_in;
   logic [AW-1:0]    leaf_ff, leaf_in, clr_ff, clr_in;
   logic             fmt_bad_ff, fmt_bad_in;
   logic [15:0]      off_ff, off_in;
   logic [RW-1:0]    row_rd_ff;
   logic [TAG_W-1:0] tag_rd_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_ff, rsp_in;

   logic [4:0]       bl, k_calc, j_calc, tag_j;
   logic             found, too_big, fmt_bad;
   logic [15:0]      start16, split_off;
   logic [AW-1:0]    leaf_calc, split_leaf, row_raddr, row_waddr, tag_waddr;
   logic [NW-1:0]    free_node, split_node, path, desc_node;
   logic [W-1:0]     left_m, right_m, mem_sib, sib, up_mask;
   logic             go_left, child_left, merge, is_free;
   logic [RW-1:0]    up_row, row_wdata;
   logic             row_we, tag_we;
   logic [TAG_W-1:0] tag_wdata;

   function automatic logic bit_of(input logic [W-1:0] v, input logic [4:0] idx);
      logic r;
      r = 1'b0;
      for (int i = 0; i < W; i++) begin
         if (5'(i) == idx) begin
            r = v[i];
         end
      end
      return r;
   endfunction

   assign is_free = (req_ff.req_type == OP_FREE);

   always_comb begin
      bl = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_ff.request_size[i]) begin
            bl = 5'(i + 1);
         end
      end
      k_calc  = (bl > 5'(MIN_ORDER)) ? bl - 5'(MIN_ORDER) : '0;
      too_big = (k_calc > 5'(LEVELS));
      found   = 1'b0;
      j_calc  = '0;
      for (int i = 0; i < W; i++) begin
         if (!found && root_ff[i] && (5'(i) >= k_calc)) begin
            j_calc = 5'(i);
            found  = 1'b1;
         end
      end
   end

   always_comb begin
      start16 = req_ff.free_offset - 16'd1;
      fmt_bad = (req_ff.free_offset == 16'd0);
      for (int i = 0; i < 16; i++) begin
         if ((i < MIN_ORDER || i >= POOL_ORDER) && start16[i]) begin
            fmt_bad = 1'b1;
         end
      end
      leaf_calc = '0;
      for (int i = 0; i < AW; i++) begin
         if (i < LEVELS && i + MIN_ORDER < 16) begin
            leaf_calc[i] = start16[i+MIN_ORDER];
         end
      end
   end

   always_comb begin
      tag_j      = tag_rd_ff - 5'd1;
      free_node  = (NW'(1) << (5'(LEVELS) - tag_j)) | (NW'(leaf_ff) >> tag_j);
      split_node = node_ff << (j_ff - k_ff);
      path       = node_ff << j_ff;
      split_leaf = '0;
      for (int i = 0; i < AW; i++) begin
         if (i < LEVELS) begin
            split_leaf[i] = path[i];
         end
      end
      split_off = 16'd1;
      for (int b = 0; b < 16; b++) begin
         if (b >= MIN_ORDER && b - MIN_ORDER < LEVELS) begin
            split_off[b] = split_leaf[b-MIN_ORDER];
         end
      end
   end

   always_comb begin
      left_m     = row_rd_ff[RW-1:W];
      right_m    = row_rd_ff[W-1:0];
      go_left    = bit_of(left_m, j_ff);
      desc_node  = (node_ff << 1) | NW'(!go_left);
      child_left = !node_ff[0];
      mem_sib    = child_left ? right_m : left_m;
      sib        = (!is_free && lvl_ff < j_ff) ? (W'(1) << lvl_ff) : mem_sib;
      merge      = bit_of(mask_ff, lvl_ff) & bit_of(sib, lvl_ff);
      up_row     = merge ? '0 : (child_left ? {mask_ff, sib} : {sib, mask_ff});
      up_mask    = merge ? (W'(1) << (lvl_ff + 5'd1)) : (mask_ff | sib);
   end

   always_comb begin
      row_raddr = cmd.up_read ? AW'(node_ff >> 1) : AW'(node_ff);
      row_we    = cmd.clear_step | cmd.up;
      row_waddr = cmd.clear_step ? clr_ff : AW'(node_ff >> 1);
      row_wdata = cmd.clear_step ? '0 : up_row;
      tag_we    = cmd.clear_step | cmd.tag_apply | cmd.split;
      priority if (cmd.clear_step) begin
         tag_waddr = clr_ff;
         tag_wdata = '0;
      end else if (cmd.tag_apply) begin
         tag_waddr = leaf_ff;
         tag_wdata = '0;
      end else begin
         tag_waddr = split_leaf;
         tag_wdata = k_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      row_rd_ff <= row_mem[row_raddr];
      if (tag_we) begin
         tag_mem[tag_waddr] <= tag_wdata;
      end
      tag_rd_ff <= tag_mem[leaf_calc];
   end

   always_comb begin
      req_in     = req_ff;
      k_in       = k_ff;
      j_in       = j_ff;
      lvl_in     = lvl_ff;
      node_in    = node_ff;
      mask_in    = mask_ff;
      leaf_in    = leaf_ff;
      fmt_bad_in = fmt_bad_ff;
      off_in     = off_ff;
      root_in    = root_ff;
      clr_in     = clr_ff;
      if (cmd.load) begin
         req_in = req_data;
      end
      if (cmd.clear_step) begin
         clr_in = clr_ff + AW'(1);
      end
      if (cmd.set_root) begin
         root_in = mask_ff;
      end
      priority if (cmd.decode) begin
         k_in       = k_calc;
         j_in       = j_calc;
         node_in    = NW'(1);
         lvl_in     = 5'(LEVELS);
         leaf_in    = leaf_calc;
         fmt_bad_in = fmt_bad;
      end else if (cmd.tag_apply) begin
         j_in    = tag_j;
         node_in = free_node;
         lvl_in  = tag_j;
         mask_in = W'(1) << tag_j;
      end else if (cmd.descend) begin
         node_in = desc_node;
         lvl_in  = lvl_ff - 5'd1;
      end else if (cmd.split) begin
         node_in = split_node;
         lvl_in  = k_ff;
         mask_in = '0;
         off_in  = split_off;
      end else if (cmd.up) begin
         node_in = node_ff >> 1;
         lvl_in  = lvl_ff + 5'd1;
         mask_in = up_mask;
      end else begin
         node_in = node_ff;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in.status      = cmd.status;
         rsp_in.user_offset = (cmd.status == STAT_OK && !is_free) ? off_ff : 16'd0;
         priority if (cmd.status == STAT_TOO_BIG || cmd.status == STAT_BAD_FREE) begin
            rsp_in.block_order = 4'd0;
         end else if (cmd.decode) begin
            rsp_in.block_order = k_calc[3:0];
         end else if (is_free) begin
            rsp_in.block_order = j_ff[3:0];
         end else begin
            rsp_in.block_order = k_ff[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      k_ff       <= k_in;
      j_ff       <= j_in;
      lvl_ff     <= lvl_in;
      node_ff    <= node_in;
      mask_ff    <= mask_in;
      leaf_ff    <= leaf_in;
      fmt_bad_ff <= fmt_bad_in;
      off_ff     <= off_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= W'(1) << LEVELS;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         root_ff      <= root_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_comb begin
      stat.clr_last = (clr_ff == '1);
      stat.is_free  = is_free;
      stat.too_big  = too_big;
      stat.no_space = !found;
      stat.bad_free = fmt_bad_ff || (tag_rd_ff == '0) || (tag_rd_ff > 5'(LEVELS + 1));
      stat.at_level = (lvl_ff == j_ff);
      stat.at_root  = (node_ff == NW'(1));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* rtl/balloc_ctrl.sv */
// Buddy allocator controller: sequences clearing, search, split and merge walks.
`default_nettype none
module balloc_ctrl
   import balloc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            priority if (stat.is_free) state_in = S_TAG;
            else if (stat.too_big || stat.no_space) state_in = S_IDLE;
            else state_in = S_DESC_RD;
         end
         S_TAG: begin
            state_in = stat.bad_free ? S_IDLE : S_UP_RD;
         end
         S_DESC_RD: begin
            state_in = stat.at_level ? S_SPLIT : S_DESC;
         end
         S_DESC: state_in = S_DESC_RD;
         S_SPLIT: state_in = S_UP_RD;
         S_UP_RD: begin
            state_in = stat.at_root ? S_IDLE : S_UP_WR;
         end
         S_UP_WR: state_in = S_UP_RD;
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.status = STAT_OK;
      busy       = 1'b1;
      unique case (state_ff)
         S_CLEAR: cmd.clear_step = 1'b1;
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            priority if (stat.is_free) begin
               cmd.finish = 1'b0;
            end else if (stat.too_big) begin
               cmd.finish = 1'b1;
               cmd.status = STAT_TOO_BIG;
            end else if (stat.no_space) begin
               cmd.finish = 1'b1;
               cmd.status = STAT_NO_SPACE;
            end else begin
               cmd.finish = 1'b0;
            end
         end
         S_TAG: begin
            if (stat.bad_free) begin
               cmd.finish = 1'b1;
               cmd.status = STAT_BAD_FREE;
            end else begin
               cmd.tag_apply = 1'b1;
            end
         end
         S_DESC_RD: cmd.up_read = 1'b0;
         S_DESC: cmd.descend = 1'b1;
         S_SPLIT: cmd.split = 1'b1;
         S_UP_RD: begin
            cmd.up_read  = 1'b1;
            cmd.set_root = stat.at_root;
            cmd.finish   = stat.at_root;
         end
         S_UP_WR: cmd.up = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/buddy_allocator.sv */
// Allocate: decode, descend to the found level, split, then walk up to the root; free: decode, read tag, walk up.
// LEVELS = POOL_ORDER-MIN_ORDER; each tree level costs one registered memory read.
// A rejected allocate shows its result after the decode state, a rejected free after the tag state.
// Throughput: one item at a time; the next start is taken the cycle the result shows.
// Reset: a clearing pass over all 2^LEVELS rows (2048 by default) runs with busy high.
// The result is shown for one cycle on rsp_valid; the receiver cannot stall it.
`default_nettype none
`include "buddy_allocator_assert.svh"
module buddy_allocator
   import balloc_pkg::*;
#(
   parameter int MIN_ORDER  = 5,
   parameter int POOL_ORDER = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_data,
   output logic         rsp_valid,
   output rsp_item_type rsp_data
);
   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   balloc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   balloc_dp #(
      .MIN_ORDER  (MIN_ORDER),
      .POOL_ORDER (POOL_ORDER)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `BALLOC_ASSERT_SAME(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   `BALLOC_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `BALLOC_ASSERT_SAME(a_err_no_offset, clock, reset, rsp_valid && rsp_data.status != STAT_OK, rsp_data.user_offset == 16'd0)
   `BALLOC_ASSERT_SAME(a_ok_offset_odd, clock, reset, rsp_valid && rsp_data.user_offset != 16'd0, rsp_data.user_offset[0])

endmodule
`default_nettype wire

/* test/tb_buddy_allocator.sv */
// Testbench for the buddy allocator: random and directed allocate/free items checked against a predictor.
`default_nettype none
module tb_buddy_allocator;
   import balloc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MIN_ORD = 5;
   localparam int POOL_ORD = 16;
   localparam int LEVELS = POOL_ORD - MIN_ORD;
   localparam int LEAVES = 1 << LEVELS;
   localparam int TREE_N = 1 << (LEVELS + 1);
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_item_type req_data = '0;
   logic rsp_valid;
   rsp_item_type rsp_data;

   buddy_allocator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   bit tree_free[TREE_N];
   logic [4:0] leaf_tag[LEAVES];
   req_item_type pending_items[$];
   rsp_item_type expected_rsps[$];
   logic [15:0] live_offsets[$];
   int mismatches = 0;
   int accepted = 0;
   bit quiet = 1'b0;
   bit drain_req = 1'b0;
   longint cycles = 0;

   function automatic rsp_item_type predict_alloc(logic [15:0] size);
      rsp_item_type r;
      int k, j, n, i, first, sel;
      longint st;
      r = '0;
      k = 0;
      while (k <= LEVELS && (longint'(1) << (MIN_ORD + k)) <= size) k++;
      if (k > LEVELS) begin
         r.status = STAT_TOO_BIG;
         return r;
      end
      n = 0;
      sel = -1;
      for (j = k; j <= LEVELS && n == 0; j++) begin
         first = 1 << (LEVELS - j);
         for (i = 0; i < first && n == 0; i++)
            if (tree_free[first + i]) begin
               n = first + i;
               sel = j;
            end
      end
      if (n == 0) begin
         r.status = STAT_NO_SPACE;
         r.block_order = 4'(k);
         return r;
      end
      j = sel;
      tree_free[n] = 0;
      while (j > k) begin
         tree_free[2 * n + 1] = 1;
         n = 2 * n;
         j--;
      end
      st = longint'(n - (1 << (LEVELS - k))) << (MIN_ORD + k);
      leaf_tag[(st >> MIN_ORD) % LEAVES] = 5'(k + 1);
      r.status = STAT_OK;
      r.user_offset = 16'(st + 1);
      r.block_order = 4'(k);
      return r;
   endfunction

   function automatic rsp_item_type predict_free(logic [15:0] offset);
      rsp_item_type r;
      int st, leaf, j, n;
      r = '0;
      r.status = STAT_BAD_FREE;
      if (offset == 0) return r;
      st = int'(offset) - 1;
      if ((st % (1 << MIN_ORD)) != 0) return r;
      leaf = (st >> MIN_ORD) % LEAVES;
      if (leaf_tag[leaf] == 0 || leaf_tag[leaf] > LEVELS + 1) return r;
      j = int'(leaf_tag[leaf]) - 1;
      leaf_tag[leaf] = 0;
      n = (1 << (LEVELS - j)) + (st >> (MIN_ORD + j));
      tree_free[n] = 1;
      while (n > 1 && tree_free[n ^ 1]) begin
         tree_free[n] = 0;
         tree_free[n ^ 1] = 0;
         n = n >> 1;
         tree_free[n] = 1;
      end
      r.status = STAT_OK;
      r.block_order = 4'(j);
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            accepted <= accepted + 1;
            if (req_data.req_type == OP_ALLOC)
               expected_rsps.push_back(predict_alloc(req_data.request_size));
            else
               expected_rsps.push_back(predict_free(req_data.free_offset));
         end
         if (start && !busy && drain_req) begin
            start <= 1'b0;
         end else if (!start || !busy) begin
            if (pending_items.size() > 0 && !drain_req
                && (quiet || $urandom_range(99) >= 23)) begin
               req_data <= pending_items.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %p", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (want.status == STAT_OK && want.user_offset != 0)
               live_offsets.push_back(want.user_offset);
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
   end

   function automatic logic [15:0] rand_size();
      int c;
      c = $urandom_range(99);
      if (c < 60) return 16'($urandom_range(200));
      if (c < 85) return 16'($urandom_range(4095));
      if (c < 97) return 16'($urandom_range(32767));
      return 16'($urandom);
   endfunction

   task automatic add_item(logic t, logic [15:0] s, logic [15:0] f);
      req_item_type it;
      it.req_type = t;
      it.request_size = s;
      it.free_offset = f;
      pending_items.push_back(it);
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      int idx;
      for (int i = 0; i < TREE_N; i++) tree_free[i] = 0;
      for (int i = 0; i < LEAVES; i++) leaf_tag[i] = 0;
      tree_free[1] = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      add_item(OP_ALLOC, 16'd0, 16'hFFFF);
      add_item(OP_ALLOC, 16'hFFFF, 16'h0);
      add_item(OP_ALLOC, 16'd31, 16'h0);
      add_item(OP_ALLOC, 16'd32, 16'h0);
      add_item(OP_ALLOC, 16'd32767, 16'h0);
      add_item(OP_ALLOC, 16'd32768, 16'h0);
      add_item(OP_FREE, 16'hFFFF, 16'd0);
      add_item(OP_FREE, 16'h0, 16'd2);
      add_item(OP_FREE, 16'h0, 16'hFFFF);
      add_item(OP_FREE, 16'h0, 16'd1);
      add_item(OP_FREE, 16'h0, 16'd1);
      add_item(OP_FREE, 16'h0, 16'd33);
      add_item(OP_FREE, 16'h0, 16'd65);
      add_item(OP_ALLOC, 16'd65535, 16'h0);
      add_item(OP_ALLOC, 16'd40000, 16'h0);
      wait_idle();
      live_offsets.delete();
      for (int i = 0; i < LEAVES; i++)
         if (leaf_tag[i] != 0) live_offsets.push_back(16'(i * 32 + 1));
      for (int i = 0; i < live_offsets.size(); i++)
         add_item(OP_FREE, 16'h0, live_offsets[i]);
      live_offsets.delete();
      wait_idle();

      for (int b = 0; b < 14; b++) begin
         drain_req = 1'b0;
         quiet = (b == 5 || b == 6);
         for (int i = 0; i < 50; i++) begin
            if (live_offsets.size() > 0 && $urandom_range(99) < 45) begin
               idx = $urandom_range(live_offsets.size() - 1);
               add_item(OP_FREE, 16'($urandom), live_offsets[idx]);
               live_offsets.delete(idx);
            end else if ($urandom_range(99) < 8) begin
               add_item(OP_FREE, 16'($urandom), 16'($urandom));
            end else begin
               add_item(OP_ALLOC, rand_size(), 16'($urandom));
            end
         end
         while (pending_items.size() > 0) @(posedge clock);
         drain_req = 1'b1;
         while (start || expected_rsps.size() > 0) @(posedge clock);
         drain_req = 1'b0;
      end
      wait_idle();
      if (mismatches == 0)
         $display("tb_buddy_allocator: PASS");
      else
         $display("tb_buddy_allocator: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_buddy_allocator: FAIL");
         $finish;
      end
   end

endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/balloc_pkg.sv
rtl/balloc_dp.sv
rtl/balloc_ctrl.sv
rtl/buddy_allocator.sv
test/tb_buddy_allocator.sv
